// ===== rtl/id3_pkg.sv =====
// Package for the ID3v2 tag byte labeler.
// Holds the parse phase type, frame and flag constants, byte class codes and
// the synchsafe size helper. No dependencies.
package id3_pkg;

    // Parse phase
    typedef enum logic [2:0] {
        PH_HEADER   = 3'd0,
        PH_EXTHDR   = 3'd1,
        PH_EXTSKIP  = 3'd2,
        PH_FRAMEHDR = 3'd3,
        PH_TEXT     = 3'd4,
        PH_FRSKIP   = 3'd5,
        PH_TAILSKIP = 3'd6,
        PH_AUDIO    = 3'd7
    } phase_t;

    // Byte class codes
    typedef enum logic [1:0] {
        CLS_TAG    = 2'd0,
        CLS_TITLE  = 2'd1,
        CLS_ARTIST = 2'd2,
        CLS_AUDIO  = 2'd3
    } byte_class_t;

    localparam int unsigned SIZE_W  = 29;
    localparam int unsigned POS_W   = 30;
    localparam int unsigned COUNT_W = 4;

    localparam logic [31:0] ID_TITLE  = 32'h5449_5432;  // TIT2
    localparam logic [31:0] ID_ARTIST = 32'h5450_4531;  // TPE1

    localparam int unsigned FLAG_EXTHDR_BIT = 6;
    localparam int unsigned FLAG_FOOTER_BIT = 4;

    localparam logic [COUNT_W-1:0] HDR_BYTES = 4'd10;
    localparam logic [COUNT_W-1:0] EXT_BYTES = 4'd6;
    localparam logic [COUNT_W-1:0] FLAGS_IDX = 4'd5;

    // One byte of a synchsafe size, not masked to 7 bits, placed by position
    function automatic logic [SIZE_W-1:0] size_part(input logic [7:0] b,
                                                    input logic [1:0] idx);
        logic [SIZE_W-1:0] part;
        begin
            case (idx)
                2'd0:    part = {b, 21'd0};
                2'd1:    part = {7'd0, b, 14'd0};
                2'd2:    part = {14'd0, b, 7'd0};
                2'd3:    part = {21'd0, b};
                default: part = '0;
            endcase
            return part;
        end
    endfunction

endpackage

// ===== rtl/id3v2_tag_text_extractor.sv =====
// ID3v2 tag byte labeler: top level with parse state and output register.
// Depends on id3_pkg.
//
// Latency: an accepted input beat is registered and shown as its output beat in the next cycle.
// Throughput: 1 byte per cycle; the only limit is the output register, which
// takes a new beat whenever it is empty or being drained in the same cycle.
// Reset: rst_n clears the parse state to the tag header phase and empties
// the output register; start_of_file on a beat restarts the parse state for that beat.
module id3v2_tag_text_extractor
    import id3_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] start_of_file
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [3:0] m_axis_tuser    // [1:0] byte_class, [2] text_start, [3] tag_done
);

    // Parse state
    phase_t              phase_reg,       phase_next;
    logic [COUNT_W-1:0]  count_reg,       count_next;
    logic [SIZE_W-1:0]   tag_size_reg,    tag_size_next;
    logic [POS_W-1:0]    tag_pos_reg,     tag_pos_next;
    logic [7:0]          flags_reg,       flags_next;
    logic [31:0]         ident_reg,       ident_next;
    logic [SIZE_W-1:0]   sec_len_reg,     sec_len_next;
    logic                title_seen_reg,  title_seen_next;
    logic                artist_seen_reg, artist_seen_next;

    // Output register
    logic                out_valid_reg,   out_valid_next;
    logic [7:0]          out_byte_reg,    out_byte_next;
    byte_class_t         out_class_reg,   out_class_next;
    logic                out_start_reg,   out_start_next;
    logic                out_done_reg,    out_done_next;

    logic                accept;
    logic [7:0]          b;
    logic                sof;

    // Effective current state (after an optional restart)
    phase_t              cur_phase;
    logic [COUNT_W-1:0]  cur_count;
    logic [SIZE_W-1:0]   cur_size;
    logic [POS_W-1:0]    cur_pos;
    logic [7:0]          cur_flags;
    logic [31:0]         cur_ident;
    logic [SIZE_W-1:0]   cur_len;
    logic                cur_title;
    logic                cur_artist;

    // Step results
    byte_class_t         step_class;
    logic                step_start;
    logic                do_walk;
    logic                do_tail;
    logic [POS_W:0]      used;
    logic                walk_ok;
    logic                tail_ok;
    logic [COUNT_W-1:0]  cnt_inc;
    logic [COUNT_W-1:0]  hdr_idx;
    logic [SIZE_W-1:0]   len_dec;
    logic [POS_W-1:0]    size_diff;

    assign b      = s_axis_tdata;
    assign sof    = s_axis_tuser;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Take a beat when the output register is empty or drains now
    assign s_axis_tready = !out_valid_reg || m_axis_tready;

    // Restart parsing on start_of_file
    always_comb
    begin
        if (sof)
        begin
            cur_phase  = PH_HEADER;
            cur_count  = '0;
            cur_size   = '0;
            cur_pos    = '0;
            cur_flags  = '0;
            cur_ident  = '0;
            cur_len    = '0;
            cur_title  = 1'b0;
            cur_artist = 1'b0;
        end
        else
        begin
            cur_phase  = phase_reg;
            cur_count  = count_reg;
            cur_size   = tag_size_reg;
            cur_pos    = tag_pos_reg;
            cur_flags  = flags_reg;
            cur_ident  = ident_reg;
            cur_len    = sec_len_reg;
            cur_title  = title_seen_reg;
            cur_artist = artist_seen_reg;
        end
    end

    // Per-byte parse step
    always_comb
    begin
        phase_next       = cur_phase;
        count_next       = cur_count;
        tag_size_next    = cur_size;
        tag_pos_next     = cur_pos;
        flags_next       = cur_flags;
        ident_next       = cur_ident;
        sec_len_next     = cur_len;
        title_seen_next  = cur_title;
        artist_seen_next = cur_artist;
        step_class       = CLS_TAG;
        step_start       = 1'b0;
        do_walk          = 1'b0;
        do_tail          = 1'b0;
        cnt_inc          = cur_count + 4'd1;
        hdr_idx          = cur_count - 4'd6;
        len_dec          = cur_len - {{(SIZE_W-1){1'b0}}, 1'b1};

        case (cur_phase)
            PH_HEADER:
            begin
                if (cur_count == FLAGS_IDX)
                    flags_next = b;
                else if (cur_count >= 4'd6)
                    tag_size_next = cur_size | size_part(b, hdr_idx[1:0]);
                count_next = cnt_inc;
                if (cnt_inc >= HDR_BYTES)
                begin
                    count_next = '0;
                    if (flags_next[FLAG_EXTHDR_BIT])
                    begin
                        sec_len_next = '0;
                        phase_next   = PH_EXTHDR;
                    end
                    else
                        do_walk = 1'b1;
                end
            end
            PH_EXTHDR:
            begin
                tag_pos_next = cur_pos + POS_W'(1);
                if (cur_count < 4'd4)
                    sec_len_next = cur_len | size_part(b, cur_count[1:0]);
                count_next = cnt_inc;
                if (cnt_inc >= EXT_BYTES)
                begin
                    count_next = '0;
                    if (sec_len_next > SIZE_W'(EXT_BYTES))
                    begin
                        sec_len_next = sec_len_next - SIZE_W'(EXT_BYTES);
                        phase_next   = PH_EXTSKIP;
                    end
                    else
                        do_walk = 1'b1;
                end
            end
            PH_FRAMEHDR:
            begin
                tag_pos_next = cur_pos + POS_W'(1);
                if (cur_count < 4'd4)
                    ident_next = {cur_ident[23:0], b};
                else if (cur_count < 4'd8)
                    sec_len_next = cur_len | size_part(b, cur_count[1:0]);
                count_next = cnt_inc;
                if (cnt_inc >= HDR_BYTES)
                begin
                    count_next = '0;
                    if (ident_next[31:24] == 8'd0)
                        do_tail = 1'b1;
                    else
                    begin
                        if (ident_next == ID_TITLE)
                            title_seen_next = 1'b1;
                        if (ident_next == ID_ARTIST)
                            artist_seen_next = 1'b1;
                        if (sec_len_next == '0)
                            do_walk = 1'b1;
                        else if (ident_next == ID_TITLE || ident_next == ID_ARTIST)
                            phase_next = PH_TEXT;
                        else
                            phase_next = PH_FRSKIP;
                    end
                end
            end
            PH_TEXT:
            begin
                tag_pos_next = cur_pos + POS_W'(1);
                if (cur_count != '0)
                    step_class = (cur_ident == ID_TITLE) ? CLS_TITLE : CLS_ARTIST;
                step_start = (cur_count == 4'd1);
                // Only zero, one and more matter here: saturate at two
                count_next = (cur_count < 4'd2) ? cnt_inc : cur_count;
                sec_len_next = len_dec;
                if (len_dec == '0)
                begin
                    count_next = '0;
                    do_walk    = 1'b1;
                end
            end
            PH_EXTSKIP, PH_FRSKIP, PH_TAILSKIP:
            begin
                tag_pos_next = cur_pos + POS_W'(1);
                sec_len_next = len_dec;
                if (len_dec == '0)
                begin
                    if (cur_phase == PH_TAILSKIP)
                        phase_next = PH_AUDIO;
                    else
                        do_walk = 1'b1;
                end
            end
            default:
            begin
                step_class = CLS_AUDIO;
            end
        endcase

        // Room left in the tag and missing frames decide whether to walk on
        used = {1'b0, tag_pos_next}
             + (flags_next[FLAG_FOOTER_BIT] ? (POS_W+1)'(20) : (POS_W+1)'(10));
        walk_ok   = ({2'b00, tag_size_next} > used)
                    && !(title_seen_next && artist_seen_next);
        tail_ok   = {1'b0, tag_size_next} > tag_pos_next;
        size_diff = {1'b0, tag_size_next} - tag_pos_next;

        if (do_walk && walk_ok)
        begin
            phase_next   = PH_FRAMEHDR;
            count_next   = '0;
            ident_next   = '0;
            sec_len_next = '0;
        end
        else if (do_walk || do_tail)
        begin
            if (tail_ok)
            begin
                sec_len_next = size_diff[SIZE_W-1:0];
                phase_next   = PH_TAILSKIP;
            end
            else
                phase_next = PH_AUDIO;
        end
    end

    // Load the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_class_next = out_class_reg;
        out_start_next = out_start_reg;
        out_done_next  = out_done_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = b;
            out_class_next = step_class;
            out_start_next = step_start;
            out_done_next  = (phase_next == PH_AUDIO);
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            count_reg       <= '0;
            tag_size_reg    <= '0;
            tag_pos_reg     <= '0;
            flags_reg       <= '0;
            ident_reg       <= '0;
            sec_len_reg     <= '0;
            title_seen_reg  <= 1'b0;
            artist_seen_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg       <= phase_next;
                count_reg       <= count_next;
                tag_size_reg    <= tag_size_next;
                tag_pos_reg     <= tag_pos_next;
                flags_reg       <= flags_next;
                ident_reg       <= ident_next;
                sec_len_reg     <= sec_len_next;
                title_seen_reg  <= title_seen_next;
                artist_seen_reg <= artist_seen_next;
            end
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_class_reg <= out_class_next;
        out_start_reg <= out_start_next;
        out_done_reg  <= out_done_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_done_reg, out_start_reg, out_class_reg};

endmodule

// ===== test/tb_id3v2_tag_text_extractor.sv =====
// Testbench for id3v2_tag_text_extractor: streams tag files, padding, broken
// files and noise through the block and checks every labeled beat against a
// local predictor. Depends on id3_pkg and the block itself.
module tb_id3v2_tag_text_extractor;
    import id3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES = 1500;
    localparam int unsigned CALM_TAIL    = 150;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 300000;

    typedef struct {
        logic [7:0] data;
        logic       sof;
        bit         drain;
    } byte_beat_t;

    typedef struct packed {
        logic [7:0]  data;
        byte_class_t cls;
        logic        start;
        logic        done;
    } byte_label_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tuser = 1'b0;    // [0] start_of_file
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_byte
    logic [3:0] m_axis_tuser;           // [1:0] byte_class, [2] text_start, [3] tag_done

    byte_beat_t  pending_bytes[$];
    byte_label_t labels_due[$];
    logic        beat_in = 1'b0;
    int unsigned label_errors = 0;
    int unsigned cycles = 0;
    int unsigned send_gap = 0;
    int unsigned send_gap_pct = 10;
    int unsigned stall_left = 0;
    int unsigned stall_pct = 10;

    // Parser state as the block should hold it
    phase_t      ph;
    logic [28:0] sec_count;
    logic [28:0] tag_size;
    logic [29:0] tag_pos;
    logic [7:0]  hdr_flags;
    logic [31:0] frame_id;
    logic [28:0] sec_len;
    logic        title_seen;
    logic        artist_seen;

    id3v2_tag_text_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_parse();
        ph          = PH_HEADER;
        sec_count   = '0;
        tag_size    = '0;
        tag_pos     = '0;
        hdr_flags   = '0;
        frame_id    = '0;
        sec_len     = '0;
        title_seen  = 1'b0;
        artist_seen = 1'b0;
    endfunction

    // Size bytes are not masked to 7 bits, so their top bits overlap
    function automatic logic [28:0] synchsafe_part(input logic [7:0] b, input logic [1:0] idx);
        return 29'(b) << (21 - 7 * int'(idx));
    endfunction

    function automatic void skip_to_tag_end();
        logic [29:0] left;
        if ({1'b0, tag_size} > tag_pos) begin
            left    = {1'b0, tag_size} - tag_pos;
            sec_len = left[28:0];
            ph      = PH_TAILSKIP;
        end
        else begin
            ph = PH_AUDIO;
        end
    endfunction

    // Keep walking frames while room is left and title or artist is missing
    function automatic void walk_or_tail();
        logic [31:0] used;
        used = 32'(tag_pos) + 32'(HDR_BYTES);
        if (hdr_flags[FLAG_FOOTER_BIT])
            used += 32'(HDR_BYTES);
        if (32'(tag_size) > used && !(title_seen && artist_seen)) begin
            ph        = PH_FRAMEHDR;
            sec_count = '0;
            frame_id  = '0;
            sec_len   = '0;
        end
        else begin
            skip_to_tag_end();
        end
    endfunction

    function automatic byte_label_t label_byte(input logic [7:0] b, input logic sof);
        byte_label_t r;
        r.data  = b;
        r.cls   = CLS_TAG;
        r.start = 1'b0;
        if (sof)
            clear_parse();
        case (ph)
            PH_HEADER: begin
                if (sec_count == 29'(FLAGS_IDX))
                    hdr_flags = b;
                else if (sec_count > 29'(FLAGS_IDX))
                    tag_size |= synchsafe_part(b, 2'(sec_count - 29'(FLAGS_IDX) - 29'd1));
                sec_count++;
                if (sec_count >= 29'(HDR_BYTES)) begin
                    sec_count = '0;
                    if (hdr_flags[FLAG_EXTHDR_BIT]) begin
                        sec_len = '0;
                        ph      = PH_EXTHDR;
                    end
                    else begin
                        walk_or_tail();
                    end
                end
            end
            PH_EXTHDR: begin
                tag_pos++;
                if (sec_count < 29'd4)
                    sec_len |= synchsafe_part(b, sec_count[1:0]);
                sec_count++;
                if (sec_count >= 29'(EXT_BYTES)) begin
                    sec_count = '0;
                    if (sec_len > 29'(EXT_BYTES)) begin
                        sec_len -= 29'(EXT_BYTES);
                        ph = PH_EXTSKIP;
                    end
                    else begin
                        walk_or_tail();
                    end
                end
            end
            PH_FRAMEHDR: begin
                tag_pos++;
                if (sec_count < 29'd4)
                    frame_id = {frame_id[23:0], b};
                else if (sec_count < 29'd8)
                    sec_len |= synchsafe_part(b, sec_count[1:0]);
                sec_count++;
                if (sec_count >= 29'(HDR_BYTES)) begin
                    sec_count = '0;
                    if (frame_id[31:24] == 8'h00) begin
                        // padding ends the walk
                        skip_to_tag_end();
                    end
                    else begin
                        if (frame_id == ID_TITLE)
                            title_seen = 1'b1;
                        else if (frame_id == ID_ARTIST)
                            artist_seen = 1'b1;
                        if (sec_len == '0)
                            walk_or_tail();
                        else if (frame_id == ID_TITLE || frame_id == ID_ARTIST)
                            ph = PH_TEXT;
                        else
                            ph = PH_FRSKIP;
                    end
                end
            end
            PH_TEXT: begin
                tag_pos++;
                // the encoding byte stays unlabeled
                if (sec_count >= 29'd1)
                    r.cls = (frame_id == ID_TITLE) ? CLS_TITLE : CLS_ARTIST;
                if (sec_count == 29'd1)
                    r.start = 1'b1;
                sec_count++;
                sec_len--;
                if (sec_len == '0) begin
                    sec_count = '0;
                    walk_or_tail();
                end
            end
            PH_EXTSKIP, PH_FRSKIP, PH_TAILSKIP: begin
                tag_pos++;
                sec_len--;
                if (sec_len == '0) begin
                    if (ph == PH_TAILSKIP)
                        ph = PH_AUDIO;
                    else
                        walk_or_tail();
                end
            end
            default: begin
                r.cls = CLS_AUDIO;
            end
        endcase
        r.done = (ph == PH_AUDIO);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] d, input logic sof, input bit drain);
        pending_bytes.push_back('{data: d, sof: sof, drain: drain});
    endtask

    task automatic add_noise_run();
        push_byte(8'($urandom), 1'b1, 1'b0);
        repeat ($urandom_range(1, 30))
            push_byte(8'($urandom), ($urandom_range(0, 15) == 0), 1'b0);
    endtask

    // Well-formed tag with random content; now and then truncated, overrun,
    // with an overlapping size byte, or without the restart flag
    task automatic add_tag_file(input bit hold_first);
        logic [7:0]  img[$];
        logic [7:0]  body[$];
        logic [7:0]  flags;
        logic [7:0]  size_lo;
        logic [31:0] ident;
        int unsigned ext_len;
        int unsigned flen;
        int unsigned tag_len;
        int unsigned keep;
        bit          padded;
        flags = 8'($urandom);
        flags[FLAG_EXTHDR_BIT] = ($urandom_range(0, 2) == 0);
        flags[FLAG_FOOTER_BIT] = ($urandom_range(0, 3) == 0);
        padded = 1'b0;
        if (flags[FLAG_EXTHDR_BIT]) begin
            ext_len = $urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(7, 24);
            body = '{8'h00, 8'h00, 8'h00, 8'(ext_len), 8'($urandom), 8'($urandom)};
            repeat ((ext_len > 6) ? ext_len - 6 : 0)
                body.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 5)) begin
            if (!padded) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: ident = ID_TITLE;
                    3, 4, 5: ident = ID_ARTIST;
                    9:       ident = '0;
                    default: begin
                        ident = $urandom;
                        if (ident[31:24] == 8'h00)
                            ident[31:24] = 8'h58;
                    end
                endcase
                padded = (ident == '0);
                if (padded)
                    flen = 0;
                else if ($urandom_range(0, 3) == 0)
                    flen = $urandom_range(0, 1);
                else
                    flen = $urandom_range(2, 24);
                body.push_back(ident[31:24]);
                body.push_back(ident[23:16]);
                body.push_back(ident[15:8]);
                body.push_back(ident[7:0]);
                body.push_back(8'h00);
                body.push_back(8'h00);
                body.push_back(8'h00);
                body.push_back(8'(flen));
                body.push_back(padded ? 8'h00 : 8'($urandom));
                body.push_back(padded ? 8'h00 : 8'($urandom));
                repeat (flen)
                    body.push_back(8'($urandom));
            end
        end
        tag_len = body.size() + $urandom_range(0, 12);
        if ($urandom_range(0, 7) == 0 && body.size() > 8)
            tag_len = body.size() - $urandom_range(1, 8);
        size_lo = 8'(tag_len & 32'h7F);
        if ($urandom_range(0, 5) == 0)
            size_lo[7] = 1'b1;
        img = '{8'h49, 8'h44, 8'h33, 8'($urandom_range(2, 4)), 8'($urandom), flags,
                8'h00, 8'h00, 8'(tag_len >> 7), size_lo};
        img = {img, body};
        while (img.size() < 10 + tag_len)
            img.push_back(8'h00);
        repeat ($urandom_range(0, 16))
            img.push_back(8'($urandom));
        keep = img.size();
        if ($urandom_range(0, 9) == 0)
            keep = $urandom_range(1, img.size());
        for (int i = 0; i < keep; i++)
            push_byte(img[i], (i == 0 && $urandom_range(0, 11) != 0), (i == 0 && hold_first));
    endtask

    // ------------------------------------------------------------------
    // Sender: hold each beat until taken, idle in bursts between beats
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (rst_n) begin
            if ($urandom_range(0, 199) == 0)
                send_gap_pct = $urandom_range(0, 2) * 20;
            if (beat_in) begin
                void'(pending_bytes.pop_front());
                if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 99) < send_gap_pct)
                    send_gap = $urandom_range(1, 14);
            end
            if (s_axis_tvalid && !beat_in) begin
                // hold the current beat
            end
            else if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap--;
            end
            else if (pending_bytes.size() > 0
                     && !(pending_bytes[0].drain && labels_due.size() != 0)) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_bytes[0].data;
                s_axis_tuser  <= pending_bytes[0].sof;
            end
            else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall in bursts, none near the end
    always @(negedge clk) begin
        if (rst_n) begin
            if ($urandom_range(0, 199) == 0)
                stall_pct = $urandom_range(0, 2) * 20;
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else begin
                m_axis_tready <= 1'b1;
                if (pending_bytes.size() > CALM_TAIL && $urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on input beats, compare on output beats
    // ------------------------------------------------------------------
    always @(posedge clk) begin : check_beats
        byte_label_t want;
        byte_label_t got;
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                labels_due.push_back(label_byte(s_axis_tdata, s_axis_tuser));
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, byte_class_t'(m_axis_tuser[1:0]),
                        m_axis_tuser[2], m_axis_tuser[3]};
                if (labels_due.size() == 0) begin
                    $display("%0t: unexpected beat: byte %h class %0d start %0b done %0b",
                             $time, got.data, got.cls, got.start, got.done);
                    label_errors++;
                end
                else begin
                    want = labels_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch: expected %h/%0d/%0b/%0b got %h/%0d/%0b/%0b",
                                 $time, want.data, want.cls, want.start, want.done,
                                 got.data, got.cls, got.start, got.done);
                        label_errors++;
                    end
                end
            end
        end
        beat_in <= rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Cycle limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0]  intro[$];
        int unsigned files;
        clear_parse();
        // Extended header too short to skip, an empty title frame, a one-byte
        // tail skip, then the byte extremes as audio
        intro = '{8'h49, 8'h44, 8'h33, 8'h04, 8'h00, 8'h40, 8'h00, 8'h00, 8'h00, 8'h11,
                  8'h00, 8'h00, 8'h00, 8'h06, 8'hA5, 8'h5A,
                  8'h54, 8'h49, 8'h54, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'hFF, 8'h00};
        for (int i = 0; i < intro.size(); i++)
            push_byte(intro[i], (i == 0), 1'b0);
        files = 0;
        while (pending_bytes.size() < RANDOM_BYTES) begin
            if (files != 2 && $urandom_range(0, 5) == 0)
                add_noise_run();
            else
                add_tag_file(files == 2 || $urandom_range(0, 9) == 0);
            files++;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || labels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (label_errors == 0 && labels_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== id3v2_tag_text_extractor.f =====
rtl/id3_pkg.sv
rtl/id3v2_tag_text_extractor.sv
test/tb_id3v2_tag_text_extractor.sv
